>>> rtl/haversine_distance_assert.svh
// Assertion macros used by the haversine distance top level
`ifndef HAVERSINE_DISTANCE_ASSERT_SVH
`define HAVERSINE_DISTANCE_ASSERT_SVH

// Check that holds on the cycle after any reset cycle
`define HCD_ASSERT_AFTER_RESET(lbl, clk, rst, cons, msg) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

// Implication checked outside reset
`define HCD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/hcd_pkg.sv
// Shared constants, types and table functions for the haversine distance block
package hcd_pkg;

  localparam int ANGLE_FRAC_BITS = 30;
  localparam int CORDIC_STAGES   = 32;

  // datapath widths
  localparam int AW       = ANGLE_FRAC_BITS + 4;   // signed angle / CORDIC word
  localparam int MW       = 28;                    // folded microdegree magnitude
  localparam int TURN_W   = 30;                    // unfolded microdegree magnitude
  localparam int DEG_W    = 64 - MW;               // degree scale constant width
  localparam int SQ_STEPS = ANGLE_FRAC_BITS + 1;   // root bits
  localparam int RAD_W    = 2 * SQ_STEPS;          // radicand width
  localparam int REM_W    = SQ_STEPS + 4;          // partial remainder width
  localparam int LAT_W    = 28;
  localparam int LON_W    = 29;
  localparam int RADIUS_W = 24;
  localparam int DIST_W   = 25;

  localparam logic [63:0] PI_Q61    = 64'h6487ED5110B4611A;
  localparam logic [63:0] DEG_SCALE = (PI_Q61 + 64'd180000000) / 64'd360000000;
  localparam logic [DEG_W-1:0] DEG_SCALE_C = DEG_SCALE[DEG_W-1:0];

  localparam logic [TURN_W-1:0] FULL_TURN    = 30'd360000000;
  localparam logic [TURN_W-1:0] HALF_TURN    = 30'd180000000;
  localparam logic [TURN_W-1:0] QUARTER_TURN = 30'd90000000;

  // degrees to radians: right shift for full and half angles
  localparam int SH_FULL = 60 - ANGLE_FRAC_BITS;
  localparam int SH_HALF = 61 - ANGLE_FRAC_BITS;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;
  localparam logic [DIST_W-1:0]   DIST_MAX     = '1;
  localparam logic [RAD_W-1:0]    A_ONE        = RAD_W'(1) << (2 * ANGLE_FRAC_BITS);

  typedef logic signed [AW-1:0] ang_t;
  typedef logic [SQ_STEPS-1:0]  root_t;
  typedef logic [REM_W-1:0]     rem_t;
  typedef logic [RAD_W-1:0]     radicand_t;

  typedef struct packed {
    ang_t x;
    ang_t y;
    ang_t z;
  } cordic_vec_t;

  typedef struct packed {
    radicand_t rad;
    rem_t      rem;
    root_t     root;
  } sqrt_st_t;

  // shift and subtract quotient, evaluated at elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i): Q62 series with truncated terms, rounded to the angle format
  function automatic ang_t atan_entry(int i);
    logic [63:0] v;
    logic [63:0] t;
    int e;
    v = '0;
    if (i == 0) begin
      v = PI_Q61 >> 1;
    end else begin
      for (int k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 62) begin
          t = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
          v = k[0] ? v - t : v + t;
        end
      end
    end
    return AW'((v + (64'd1 << (61 - ANGLE_FRAC_BITS))) >> (62 - ANGLE_FRAC_BITS));
  endfunction

  // CORDIC start value: round(2^(60+F) / gain), gain from a Q60 vectoring pass
  function automatic logic [63:0] inv_gain_calc();
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] nx;
    logic signed [63:0] ny;
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] rem;
    x = 64'sh1000000000000000;
    y = '0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (!y[63]) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
      end
      x = nx;
      y = ny;
    end
    d   = x;
    q   = '0;
    rem = 64'd1;
    for (int i = 0; i < 60 + ANGLE_FRAC_BITS; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= d) begin
        rem  = rem - d;
        q[0] = 1'b1;
      end
    end
    if (rem >= d - rem) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

  localparam ang_t INV_GAIN = AW'(inv_gain_calc());

endpackage

>>> rtl/hcd_cordic_cell.sv
// One CORDIC micro-rotation, registered, in rotation or vectoring mode
module hcd_cordic_cell #(
  parameter int STAGE  = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic                 clk,
  input  hcd_pkg::cordic_vec_t d,
  output hcd_pkg::cordic_vec_t q
);

  localparam hcd_pkg::ang_t ATAN_I = hcd_pkg::atan_entry(STAGE);

  hcd_pkg::ang_t x, y, z, xs, ys;
  logic ccw;
  hcd_pkg::cordic_vec_t q_next;

  assign x  = d.x;
  assign y  = d.y;
  assign z  = d.z;
  assign xs = x >>> STAGE;
  assign ys = y >>> STAGE;

  // rotation follows the residual angle, vectoring drives y toward zero
  assign ccw = VECTOR ? y[hcd_pkg::AW-1] : !z[hcd_pkg::AW-1];

  always_comb begin
    if (ccw) begin
      q_next.x = x - ys;
      q_next.y = y + xs;
      q_next.z = z - ATAN_I;
    end else begin
      q_next.x = x + ys;
      q_next.y = y - xs;
      q_next.z = z + ATAN_I;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

>>> rtl/hcd_cordic.sv
// Row of CORDIC cells, one micro-rotation per cycle
module hcd_cordic #(
  parameter bit VECTOR = 1'b0
) (
  input  logic                 clk,
  input  hcd_pkg::cordic_vec_t din,
  output hcd_pkg::cordic_vec_t dout
);

  localparam int N = hcd_pkg::CORDIC_STAGES;

  hcd_pkg::cordic_vec_t chain [N+1];

  assign chain[0] = din;

  for (genvar g = 0; g < N; g++) begin : g_cell
    hcd_cordic_cell #(
      .STAGE (g),
      .VECTOR(VECTOR)
    ) u_cell (
      .clk(clk),
      .d  (chain[g]),
      .q  (chain[g+1])
    );
  end

  assign dout = chain[N];

endmodule

>>> rtl/hcd_sqrt_cell.sv
// One digit of a restoring square root, registered
module hcd_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  hcd_pkg::sqrt_st_t d,
  output hcd_pkg::sqrt_st_t q
);

  localparam int SQ = hcd_pkg::SQ_STEPS;
  localparam int RW = hcd_pkg::REM_W;

  logic [1:0] pair;
  hcd_pkg::rem_t cur, trial;
  hcd_pkg::sqrt_st_t q_next;

  // bring down the next two radicand bits and try root*4+1
  assign pair  = d.rad[hcd_pkg::RAD_W-1-2*STEP -: 2];
  assign cur   = {d.rem[RW-3:0], pair};
  assign trial = {{(RW-SQ-2){1'b0}}, d.root, 2'b01};

  always_comb begin
    q_next.rad = d.rad;
    if (cur >= trial) begin
      q_next.rem  = cur - trial;
      q_next.root = {d.root[SQ-2:0], 1'b1};
    end else begin
      q_next.rem  = cur;
      q_next.root = {d.root[SQ-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

>>> rtl/hcd_sqrt.sv
// Row of square-root cells, one root bit per cycle, floor result
module hcd_sqrt (
  input  logic                clk,
  input  hcd_pkg::radicand_t  din,
  output hcd_pkg::root_t      root
);

  localparam int K = hcd_pkg::SQ_STEPS;

  hcd_pkg::sqrt_st_t chain [K+1];

  assign chain[0].rad  = din;
  assign chain[0].rem  = '0;
  assign chain[0].root = '0;

  for (genvar g = 0; g < K; g++) begin : g_cell
    hcd_sqrt_cell #(
      .STEP(g)
    ) u_cell (
      .clk(clk),
      .d  (chain[g]),
      .q  (chain[g+1])
    );
  end

  assign root = chain[K].root;

endmodule

>>> rtl/haversine_distance.sv
// Haversine great-circle distance, fully pipelined top level
//
// Takes one point pair per cycle whenever start is high (busy is only high
// during reset) and returns its distance in meters with done high for one
// cycle; results cannot be held off, so the receiver must take distance_m
// whenever done is high. The latency is set by the cell rows: two 32-cell
// CORDIC rows (sine/cosine, then arctangent), a 31-cell square root row, and
// eleven stages of conversion, multiply and rounding. The user must write the
// radius via cfg_write/cfg_data while no item is in flight; nothing enforces it.
module haversine_distance (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [hcd_pkg::LAT_W-1:0]     lat_a,
  input  logic signed [hcd_pkg::LON_W-1:0]     lon_a,
  input  logic signed [hcd_pkg::LAT_W-1:0]     lat_b,
  input  logic signed [hcd_pkg::LON_W-1:0]     lon_b,
  input  logic                                 cfg_write,
  input  logic        [hcd_pkg::RADIUS_W-1:0]  cfg_data,
  output logic                                 done,
  output logic        [hcd_pkg::DIST_W-1:0]    distance_m
);

  localparam int F     = hcd_pkg::ANGLE_FRAC_BITS;
  localparam int N     = hcd_pkg::CORDIC_STAGES;
  localparam int K     = hcd_pkg::SQ_STEPS;
  localparam int AW    = hcd_pkg::AW;
  localparam int MW    = hcd_pkg::MW;
  localparam int TW    = hcd_pkg::TURN_W;
  localparam int LW    = hcd_pkg::LAT_W;
  localparam int OW    = hcd_pkg::LON_W;
  localparam int PW    = hcd_pkg::RAD_W;
  localparam int MQW   = 2 * (AW - 1);
  localparam int DPW   = hcd_pkg::RADIUS_W + AW - 1;
  localparam int LAT   = 2 * N + K + 11;

  localparam logic [63:0]    RND_HALF = 64'd1 << (hcd_pkg::SH_HALF - 1);
  localparam logic [63:0]    RND_FULL = 64'd1 << (hcd_pkg::SH_FULL - 1);
  localparam logic [MQW-1:0] RND_Q    = MQW'(1) << (F - 1);
  localparam logic [DPW-1:0] RND_D    = DPW'(1) << (F - 2);

  // magnitude of a signed angle word
  function automatic logic [AW-2:0] mag(hcd_pkg::ang_t v);
    logic [AW-1:0] r;
    r = v[AW-1] ? -v : v;
    return r[AW-2:0];
  endfunction

  // difference to [0, 180] degrees
  function automatic logic [MW-1:0] half_fold(logic [TW-1:0] m);
    logic [TW-1:0] r;
    r = m;
    if (r >= hcd_pkg::FULL_TURN) begin
      r = r - hcd_pkg::FULL_TURN;
    end
    if (r > hcd_pkg::HALF_TURN) begin
      r = hcd_pkg::FULL_TURN - r;
    end
    return r[MW-1:0];
  endfunction

  // latitude to [0, 90] degrees; top bit flags a negated cosine
  function automatic logic [MW:0] lat_fold(logic [TW-1:0] m);
    logic [TW-1:0] r;
    logic neg;
    r   = m;
    neg = 1'b0;
    if (r > hcd_pkg::QUARTER_TURN) begin
      r   = hcd_pkg::HALF_TURN - r;
      neg = 1'b1;
    end
    return {neg, r[MW-1:0]};
  endfunction

  logic accept;
  logic [hcd_pkg::RADIUS_W-1:0] radius;
  logic [LAT-1:0] vld;

  assign busy   = rst;
  assign accept = start && !busy;

  // radius register
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= hcd_pkg::RADIUS_RESET;
    end else if (cfg_write) begin
      radius <= cfg_data;
    end
  end

  // item valid line, one bit per pipeline stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  assign done = vld[LAT-1];

  // stage 1: differences, magnitudes and folding
  logic signed [LW:0] dlat;
  logic signed [OW:0] dlon;
  logic [LW:0]   dlat_u;
  logic [OW:0]   dlon_u;
  logic [LW-1:0] la_u, lb_u;
  logic [MW:0]   lfa, lfb;
  logic [MW-1:0] ang_m [4];
  logic [1:0]    neg1;

  assign dlat   = {lat_b[LW-1], lat_b} - {lat_a[LW-1], lat_a};
  assign dlon   = {lon_b[OW-1], lon_b} - {lon_a[OW-1], lon_a};
  assign dlat_u = dlat[LW] ? -dlat : dlat;
  assign dlon_u = dlon[OW] ? -dlon : dlon;
  assign la_u   = lat_a[LW-1] ? -lat_a : lat_a;
  assign lb_u   = lat_b[LW-1] ? -lat_b : lat_b;
  assign lfa    = lat_fold({{(TW-LW){1'b0}}, la_u});
  assign lfb    = lat_fold({{(TW-LW){1'b0}}, lb_u});

  always_ff @(posedge clk) begin
    ang_m[0] <= half_fold({{(TW-LW-1){1'b0}}, dlat_u});
    ang_m[1] <= half_fold(dlon_u);
    ang_m[2] <= lfa[MW-1:0];
    ang_m[3] <= lfb[MW-1:0];
    neg1     <= {lfb[MW], lfa[MW]};
  end

  // stage 2: microdegrees times pi/180 scale
  logic [63:0] prod [4];
  logic [1:0]  neg_q [N+1];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      prod[j] <= {{hcd_pkg::DEG_W{1'b0}}, ang_m[j]} * {{MW{1'b0}}, hcd_pkg::DEG_SCALE_C};
    end
    neg_q[0] <= neg1;
    for (int j = 1; j <= N; j++) begin
      neg_q[j] <= neg_q[j-1];
    end
  end

  // sine and cosine rows: half differences, then both latitudes
  hcd_pkg::cordic_vec_t rot_in [4];
  hcd_pkg::cordic_vec_t rot_out [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rot_in[j].x = hcd_pkg::INV_GAIN;
      rot_in[j].y = '0;
      if (j < 2) begin
        rot_in[j].z = AW'((prod[j] + RND_HALF) >> hcd_pkg::SH_HALF);
      end else begin
        rot_in[j].z = AW'((prod[j] + RND_FULL) >> hcd_pkg::SH_FULL);
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_rot
    hcd_cordic #(
      .VECTOR(1'b0)
    ) u_rot (
      .clk (clk),
      .din (rot_in[g]),
      .dout(rot_out[g])
    );
  end

  // m1: cos product and sin^2 of half latitude difference
  logic ca_neg, cb_neg;
  logic [MQW-1:0] pw, p1_m1;
  logic           w_neg;
  hcd_pkg::ang_t  s2_m1;

  assign ca_neg = (rot_out[2].x != '0) && (neg_q[N][0] ^ rot_out[2].x[AW-1]);
  assign cb_neg = (rot_out[3].x != '0) && (neg_q[N][1] ^ rot_out[3].x[AW-1]);

  always_ff @(posedge clk) begin
    pw    <= MQW'(mag(rot_out[2].x)) * MQW'(mag(rot_out[3].x));
    w_neg <= ca_neg ^ cb_neg;
    p1_m1 <= MQW'(mag(rot_out[0].y)) * MQW'(mag(rot_out[0].y));
    s2_m1 <= rot_out[1].y;
  end

  // m2: round w
  logic [MQW-1:0] pw_r;
  logic [AW-2:0]  wm;
  logic           wneg2;
  logic [MQW-1:0] p1_m2;
  hcd_pkg::ang_t  s2_m2;

  assign pw_r = (pw + RND_Q) >> F;

  always_ff @(posedge clk) begin
    wm    <= pw_r[AW-2:0];
    wneg2 <= w_neg && (pw_r[AW-2:0] != '0);
    p1_m2 <= p1_m1;
    s2_m2 <= s2_m1;
  end

  // m3: t = s2 * w
  logic [MQW-1:0] pt, p1_m3;
  logic           tneg;
  hcd_pkg::ang_t  s2_m3;

  always_ff @(posedge clk) begin
    pt    <= MQW'(mag(s2_m2)) * MQW'(wm);
    tneg  <= s2_m2[AW-1] != wneg2;
    p1_m3 <= p1_m2;
    s2_m3 <= s2_m2;
  end

  // m4: round t
  logic [MQW-1:0] pt_r;
  logic [AW-2:0]  tm;
  logic           tneg4;
  logic [MQW-1:0] p1_m4;
  hcd_pkg::ang_t  s2_m4;

  assign pt_r = (pt + RND_Q) >> F;

  always_ff @(posedge clk) begin
    tm    <= pt_r[AW-2:0];
    tneg4 <= tneg && (pt_r[AW-2:0] != '0);
    p1_m4 <= p1_m3;
    s2_m4 <= s2_m3;
  end

  // m5: second term t * s2
  logic [MQW-1:0] p2_m5, p1_m5;
  logic           differ;

  always_ff @(posedge clk) begin
    p2_m5  <= MQW'(tm) * MQW'(mag(s2_m4));
    differ <= tneg4 != s2_m4[AW-1];
    p1_m5  <= p1_m4;
  end

  // m6: a = p1 +/- p2, clamped to [0, 1]
  logic [MQW-1:0] a_raw;
  logic [PW-1:0]  a_c;

  always_comb begin
    if (differ) begin
      a_raw = (p2_m5 <= p1_m5) ? p1_m5 - p2_m5 : '0;
    end else begin
      a_raw = p1_m5 + p2_m5;
    end
  end

  always_ff @(posedge clk) begin
    a_c <= (a_raw > MQW'(hcd_pkg::A_ONE)) ? hcd_pkg::A_ONE : a_raw[PW-1:0];
  end

  // m7: radicands a and 1 - a
  hcd_pkg::radicand_t rad_u, rad_v;

  always_ff @(posedge clk) begin
    rad_u <= a_c;
    rad_v <= hcd_pkg::A_ONE - a_c;
  end

  // square roots
  hcd_pkg::root_t u_root, v_root;

  hcd_sqrt u_sqrt_u (
    .clk (clk),
    .din (rad_u),
    .root(u_root)
  );

  hcd_sqrt u_sqrt_v (
    .clk (clk),
    .din (rad_v),
    .root(v_root)
  );

  // arctangent row
  hcd_pkg::cordic_vec_t vec_in, vec_out;

  assign vec_in.x = {{(AW-K){1'b0}}, v_root};
  assign vec_in.y = {{(AW-K){1'b0}}, u_root};
  assign vec_in.z = '0;

  hcd_cordic #(
    .VECTOR(1'b1)
  ) u_vec (
    .clk (clk),
    .din (vec_in),
    .dout(vec_out)
  );

  // radius times angle, then round to meters and saturate
  logic [AW-2:0]  zc;
  logic [DPW-1:0] dp, dr;

  assign zc = vec_out.z[AW-1] ? '0 : vec_out.z[AW-2:0];
  assign dr = (dp + RND_D) >> (F - 1);

  always_ff @(posedge clk) begin
    dp         <= {{(AW-1){1'b0}}, radius} * {{hcd_pkg::RADIUS_W{1'b0}}, zc};
    distance_m <= (dr > DPW'(hcd_pkg::DIST_MAX)) ? hcd_pkg::DIST_MAX
                                                 : dr[hcd_pkg::DIST_W-1:0];
  end

  // checks
  `include "haversine_distance_assert.svh"

  `HCD_ASSERT_AFTER_RESET(a_reset_no_done, clk, rst, !done, "result strobe after reset")
  `HCD_ASSERT_IMPLY(a_item_done, clk, rst, accept, ##LAT done, "item produced no result")
  `HCD_ASSERT_IMPLY(a_back_to_back, clk, rst, accept ##1 accept, ##(LAT-1) done ##1 done, "back-to-back items lost")

endmodule
